>>> rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants of the Huffman table bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int DEF_SYMBOL_BITS  = 9;
   localparam int DEF_MAX_CODE_LEN = 32;

   localparam int SYMBOL_W       = 9;
   localparam int CODE_WORD_BITS = 32;
   localparam int LEN_W          = 6;
   localparam int BYTE_BITS      = 8;
   localparam int PEND_W         = 7;
   localparam int PCNT_W         = 3;
   localparam int ACC_W          = PEND_W + CODE_WORD_BITS;
   localparam int MAX_BYTES      = 4;
   localparam int NCNT_W         = 3;

   localparam logic [BYTE_BITS-1:0] TERMINATOR = 8'h20;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_FLUSH  = 2'd2
   } func_type;

   // bytes produced by one item plus the accumulator state it leaves
   typedef struct packed {
      logic [NCNT_W-1:0]                    n;
      logic [MAX_BYTES-1:0][BYTE_BITS-1:0]  bytes;
      logic [PEND_W-1:0]                    pend_bits;
      logic [PCNT_W-1:0]                    pend_cnt;
   } pack_res_type;

endpackage

>>> rtl/hbp_table.sv
// ----------------------------------------------------------------------------
// hbp_table
// Code table memory: one write port for loads, registered read for lookups.
// ----------------------------------------------------------------------------
module hbp_table
   import hbp_pkg::*;
#(
   parameter int SYMBOL_BITS  = DEF_SYMBOL_BITS,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic                      rd_en,
   input  logic [SYMBOL_BITS-1:0]    addr,
   input  logic [CODE_WORD_BITS-1:0] wr_code,
   input  logic [LEN_W-1:0]          wr_len,
   output logic [CODE_WORD_BITS-1:0] rd_code,
   output logic [LEN_W-1:0]          rd_len
);

   localparam int DEPTH   = 1 << SYMBOL_BITS;
   localparam int LEN_LIM = (MAX_CODE_LEN < CODE_WORD_BITS) ? MAX_CODE_LEN : CODE_WORD_BITS;
   localparam logic [LEN_W-1:0] LEN_LIM_V = LEN_W'(LEN_LIM);

   logic [LEN_W+CODE_WORD_BITS-1:0] mem [DEPTH];
   logic [LEN_W+CODE_WORD_BITS-1:0] rd_data_ff;
   logic [LEN_W-1:0]                len_clamped;

   // saturate overlong lengths when stored
   assign len_clamped = (wr_len > LEN_LIM_V) ? LEN_LIM_V : wr_len;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= {len_clamped, wr_code};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_code = rd_data_ff[CODE_WORD_BITS-1:0];
   assign rd_len  = rd_data_ff[LEN_W+CODE_WORD_BITS-1:CODE_WORD_BITS];

endmodule

>>> rtl/hbp_pack.sv
// ----------------------------------------------------------------------------
// hbp_pack
// Bit packing: merge a code word with the pending bits and cut out bytes.
// ----------------------------------------------------------------------------
module hbp_pack
   import hbp_pkg::*;
(
   input  func_type                  func,
   input  logic [CODE_WORD_BITS-1:0] code,
   input  logic [LEN_W-1:0]          len,
   input  logic [PEND_W-1:0]         pend_bits,
   input  logic [PCNT_W-1:0]         pend_cnt,
   output pack_res_type              res
);

   logic [CODE_WORD_BITS:0]   code_mask;
   logic [CODE_WORD_BITS-1:0] code_m;
   logic [ACC_W-1:0]          acc;
   logic [LEN_W-1:0]          total;
   logic [ACC_W-1:0]          aligned;
   logic [BYTE_BITS-1:0]      tail_mask;
   logic [BYTE_BITS-1:0]      flush_byte;

   assign code_mask  = ((CODE_WORD_BITS+1)'(1) << len) - (CODE_WORD_BITS+1)'(1);
   assign code_m     = code & code_mask[CODE_WORD_BITS-1:0];
   assign acc        = ({{CODE_WORD_BITS{1'b0}}, pend_bits} << len)
                       | {{PEND_W{1'b0}}, code_m};
   assign total      = LEN_W'(pend_cnt) + len;
   // left-align so the earliest bit sits at the top
   assign aligned    = acc << (LEN_W'(ACC_W) - total);
   assign tail_mask  = (BYTE_BITS'(1) << total[PCNT_W-1:0]) - BYTE_BITS'(1);
   assign flush_byte = BYTE_BITS'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt}));

   always_comb begin
      res           = '0;
      res.pend_bits = pend_bits;
      res.pend_cnt  = pend_cnt;
      case (func)
         FUNC_ENCODE: begin
            res.n = total[LEN_W-1:PCNT_W];
            for (int k = 0; k < MAX_BYTES; k++) begin
               res.bytes[k] = aligned[ACC_W-1-BYTE_BITS*k -: BYTE_BITS];
            end
            res.pend_bits = acc[PEND_W-1:0] & tail_mask[PEND_W-1:0];
            res.pend_cnt  = total[PCNT_W-1:0];
         end
         FUNC_FLUSH: begin
            if (pend_cnt != '0) begin
               res.n        = NCNT_W'(2);
               res.bytes[0] = flush_byte;
               res.bytes[1] = TERMINATOR;
            end else begin
               res.n        = NCNT_W'(1);
               res.bytes[0] = TERMINATOR;
            end
            res.pend_bits = '0;
            res.pend_cnt  = '0;
         end
         default: begin
            res.n = '0;
         end
      endcase
   end

endmodule

>>> rtl/hbp_obuf.sv
// ----------------------------------------------------------------------------
// hbp_obuf
// Result byte buffer: holds an item's bytes, drains one a cycle unless stalled.
// ----------------------------------------------------------------------------
module hbp_obuf
   import hbp_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [NCNT_W-1:0]                   load_n,
   input  logic [MAX_BYTES-1:0][BYTE_BITS-1:0] load_bytes,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [BYTE_BITS-1:0]                rsp_out_byte,
   output logic                                rsp_last,
   output logic                                free
);

   logic [NCNT_W-1:0]                   cnt_ff, cnt_in;
   logic [MAX_BYTES-1:0][BYTE_BITS-1:0] bytes_ff, bytes_in;
   logic                                take;

   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_out_byte = bytes_ff[0];
   assign rsp_last     = (cnt_ff == NCNT_W'(1));
   assign take         = rsp_valid && !rsp_stall;
   assign free         = (cnt_ff == '0) || (rsp_last && !rsp_stall);

   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      if (load) begin
         cnt_in   = load_n;
         bytes_in = load_bytes;
      end else if (take) begin
         cnt_in = cnt_ff - NCNT_W'(1);
         // advance the next byte to the head
         for (int k = 0; k < MAX_BYTES - 1; k++) begin
            bytes_in[k] = bytes_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule

>>> rtl/huffman_table_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_packer_unit
// Huffman encoder with a loadable code table and an MSB-first byte packer.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    func, symbol, code_bits, code_length
//   rsp      out        rsp_valid/stall    out_byte, last
//
// An item is taken every cycle while each item yields at most one byte and the
// result is not stalled; the result port moves one byte per cycle unless
// stalled, and an item gives up to four bytes (a full 32-bit code on top of
// pending bits). After the request transfer an item passes the registered
// table read, then is packed into the output buffer that sends its first byte.
// Reset clears the pending bits and the pipeline; the table itself is not
// cleared and must be loaded before a symbol is encoded.
// A stalled result holds the buffer; the request side then stalls as soon as
// the packing stage holds an item that produces bytes.
// ----------------------------------------------------------------------------
module huffman_table_bit_packer_unit
   import hbp_pkg::*;
#(
   parameter int SYMBOL_BITS  = DEF_SYMBOL_BITS,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_func,
   input  logic signed [SYMBOL_W-1:0] req_symbol,
   input  logic [CODE_WORD_BITS-1:0]  req_code_bits,
   input  logic [LEN_W-1:0]           req_code_length,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [BYTE_BITS-1:0]       rsp_out_byte,
   output logic                       rsp_last
);

   logic                                 req_xfer;
   logic signed [SYMBOL_BITS+SYMBOL_W-1:0] sym_ext;
   logic [SYMBOL_BITS-1:0]               tbl_addr;
   logic [CODE_WORD_BITS-1:0]            rd_code;
   logic [LEN_W-1:0]                     rd_len;

   // packing stage
   logic                                 s1_vld_ff, s1_vld_in;
   func_type                             s1_func_ff, s1_func_in;
   logic                                 s1_adv;

   // bit accumulator
   logic [PEND_W-1:0]                    pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]                    pend_cnt_ff, pend_cnt_in;

   pack_res_type                         res;
   logic                                 buf_free;
   logic                                 buf_load;

   assign req_xfer = req_valid && !req_stall;

   // table index: low SYMBOL_BITS bits of the two's complement symbol
   assign sym_ext  = (SYMBOL_BITS+SYMBOL_W)'(req_symbol);
   assign tbl_addr = sym_ext[SYMBOL_BITS-1:0];

   hbp_table #(
      .SYMBOL_BITS  (SYMBOL_BITS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_xfer && (req_func == FUNC_LOAD)),
      .rd_en   (req_xfer),
      .addr    (tbl_addr),
      .wr_code (req_code_bits),
      .wr_len  (req_code_length),
      .rd_code (rd_code),
      .rd_len  (rd_len)
   );

   hbp_pack u_pack (
      .func      (s1_func_ff),
      .code      (rd_code),
      .len       (rd_len),
      .pend_bits (pend_bits_ff),
      .pend_cnt  (pend_cnt_ff),
      .res       (res)
   );

   // items without bytes never wait on the output buffer
   assign s1_adv    = s1_vld_ff && ((res.n == '0) || buf_free);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign buf_load  = s1_adv && (res.n != '0);

   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_func_in   = s1_func_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (s1_adv) begin
         s1_vld_in    = 1'b0;
         pend_bits_in = res.pend_bits;
         pend_cnt_in  = res.pend_cnt;
      end
      if (req_xfer) begin
         s1_vld_in  = 1'b1;
         s1_func_in = func_type'(req_func);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff <= s1_func_in;
   end

   hbp_obuf u_obuf (
      .clock        (clock),
      .reset        (reset),
      .load         (buf_load),
      .load_n       (res.n),
      .load_bytes   (res.bytes),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .free         (buf_free)
   );

endmodule

>>> rtl/hbp_checker.sv
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks of the bit packer, attached by bind.
// ----------------------------------------------------------------------------
module hbp_checker
   import hbp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [1:0]                 req_func,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [BYTE_BITS-1:0]       rsp_out_byte,
   input logic                       rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // reset empties the output
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // bytes of one item leave back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside an item's bytes");

   // an accepted flush is followed by a valid result
   a_flush_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == FUNC_FLUSH) |-> ##2 rsp_valid)
      else $error("flush gave no result");

endmodule

bind huffman_table_bit_packer_unit hbp_checker u_hbp_checker (.*);

>>> tb/sv/huffman_table_bit_packer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_table_bit_packer_unit_tb
// Self-checking bench for the Huffman table bit packer. The stimulus loads code
// table entries, encodes loaded symbols, flushes the bit accumulator and sends
// the unused func code. A scoreboard class tracks its own copy of the table and
// pending bits and compares every output byte, and its last flag, in order.
// ----------------------------------------------------------------------------
import hbp_pkg::*;

typedef struct packed {
   logic [BYTE_BITS-1:0] value;
   logic                 last;
} due_byte_type;

class packed_byte_scoreboard;
   logic [CODE_WORD_BITS-1:0] code_tab [0:511];
   logic [LEN_W-1:0]          len_tab  [0:511];
   logic [PEND_W-1:0]         pend_bits;
   int                        pend_cnt;
   due_byte_type              bytes_due [$];
   int                        errors;

   function new();
      pend_bits = '0;
      pend_cnt  = 0;
      errors    = 0;
   endfunction

   function int outstanding();
      return bytes_due.size();
   endfunction

   // Work out the bytes that one accepted request transfer must produce.
   function void note_request(logic [1:0] func, logic [SYMBOL_W-1:0] sym,
                              logic [CODE_WORD_BITS-1:0] cb, logic [LEN_W-1:0] cl);
      int                   lim;
      int                   len;
      int                   total;
      int                   n;
      logic [63:0]          acc;
      logic [63:0]          sh;
      logic [BYTE_BITS-1:0] got [MAX_BYTES];
      logic [BYTE_BITS-1:0] pad;
      case (func)
         FUNC_LOAD: begin
            lim = (DEF_MAX_CODE_LEN < CODE_WORD_BITS) ? DEF_MAX_CODE_LEN : CODE_WORD_BITS;
            code_tab[sym] = cb;
            len_tab[sym]  = (int'(cl) > lim) ? LEN_W'(lim) : cl;
         end
         FUNC_ENCODE: begin
            len   = len_tab[sym];
            acc   = ({57'd0, pend_bits} << len)
                  | ({32'd0, code_tab[sym]} & ((64'd1 << len) - 64'd1));
            total = pend_cnt + len;
            n     = 0;
            while (total >= BYTE_BITS && n < MAX_BYTES) begin
               sh     = acc >> (total - BYTE_BITS);
               got[n] = sh[BYTE_BITS-1:0];
               n++;
               total -= BYTE_BITS;
            end
            for (int k = 0; k < n; k++)
               bytes_due.insert(bytes_due.size(), due_byte_type'{got[k], k == n - 1});
            sh        = acc & ((64'd1 << total) - 64'd1);
            pend_bits = sh[PEND_W-1:0];
            pend_cnt  = total;
         end
         FUNC_FLUSH: begin
            if (pend_cnt > 0) begin
               pad = {1'b0, pend_bits} << (BYTE_BITS - pend_cnt);
               bytes_due.insert(bytes_due.size(), due_byte_type'{pad, 1'b0});
            end
            bytes_due.insert(bytes_due.size(), due_byte_type'{TERMINATOR, 1'b1});
            pend_bits = '0;
            pend_cnt  = 0;
         end
         default: ;
      endcase
   endfunction

   // Compare one accepted output byte with the oldest one due.
   function void check_byte(logic [BYTE_BITS-1:0] value, logic last);
      due_byte_type due;
      if (bytes_due.size() == 0) begin
         $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                  $time, value, last);
         errors++;
         return;
      end
      due = bytes_due.pop_front();
      if (value !== due.value) begin
         $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                  $time, due.value, value);
         errors++;
      end
      if (last !== due.last) begin
         $display("%0t: last mismatch, expected %0b, actual %0b", $time, due.last, last);
         errors++;
      end
   endfunction
endclass

module huffman_table_bit_packer_unit_tb;

   // the request port has no code for func value 3; the block must ignore it
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         NUM_RANDOM  = 106;
   localparam int         DRAIN_CYCLES = 20;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_func;
   logic signed [SYMBOL_W-1:0] req_symbol;
   logic [CODE_WORD_BITS-1:0]  req_code_bits;
   logic [LEN_W-1:0]           req_code_length;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [BYTE_BITS-1:0]       rsp_out_byte;
   logic                       rsp_last;

   packed_byte_scoreboard sb;

   // table entries that hold a loaded code; only these are ever encoded
   bit filled [0:511];
   int filled_list [$];
   // while set, the sender puts no gaps between transfers
   bit steady;

   huffman_table_bit_packer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Drive one request and hold it until the transfer happens. Every input
   // changes at the falling edge only; each edge assigns valid at most once.
   task automatic send_item(input logic [1:0] func, input logic [SYMBOL_W-1:0] sym,
                            input logic [CODE_WORD_BITS-1:0] cb,
                            input logic [LEN_W-1:0] cl);
      int gap;
      gap = steady ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_func        = func;
      req_symbol      = sym;
      req_code_bits   = cb;
      req_code_length = cl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(func, sym, cb, cl);
      if (func == FUNC_LOAD && !filled[sym]) begin
         filled[sym] = 1'b1;
         filled_list.insert(filled_list.size(), int'(sym));
      end
   endtask

   // Pick a load length: zero now and then, mostly short codes, some long,
   // and a few above the code word width to exercise saturation.
   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return '0;
      if (r < 65) return LEN_W'($urandom_range(1, 12));
      if (r < 90) return LEN_W'($urandom_range(13, 32));
      return LEN_W'($urandom_range(33, 63));
   endfunction

   // Result side: random stall pattern, with stretches of no stall at all.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
         repeat (run) begin
            @(negedge clock);
            rsp_stall = 1'b0;
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         repeat (run) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
      end
   end

   // Check every result transfer against the oldest byte due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_byte(rsp_out_byte, rsp_last);
   end

   // Stop a hung run; bounds the slowest legal run several times over.
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int r;
      int idx;
      sb              = new();
      steady          = 1'b1;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_LOAD;
      req_symbol      = '0;
      req_code_bits   = '0;
      req_code_length = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: table extremes first, then encodes over them.
      send_item(FUNC_LOAD, 9'h100, 32'hFFFF_FFFF, 6'd32);  // most negative symbol, full code
      send_item(FUNC_LOAD, 9'h0FF, 32'h0000_0005, 6'd3);   // most positive symbol
      send_item(FUNC_LOAD, 9'h000, 32'hDEAD_BEEF, 6'd0);   // zero-length code
      send_item(FUNC_LOAD, 9'h1FF, 32'hFFFF_FFFF, 6'd63);  // overlong length saturates
      send_item(FUNC_LOAD, 9'h001, 32'hFFFF_FFF2, 6'd4);   // bits above length dropped
      send_item(FUNC_LOAD, 9'h002, 32'h0000_00A5, 6'd33);  // just over the limit
      send_item(FUNC_LOAD, 9'h003, 32'h0000_0000, 6'd1);
      send_item(FUNC_FLUSH, 9'h000, 32'h0, 6'd0);          // empty flush: terminator only
      steady = 1'b0;
      send_item(FUNC_ENCODE, 9'h0FF, 32'h0, 6'd0);
      send_item(FUNC_ENCODE, 9'h000, 32'h0, 6'd0);         // zero length: no byte
      send_item(FUNC_ENCODE, 9'h100, 32'h0, 6'd0);         // four bytes at once
      send_item(FUNC_ENCODE, 9'h1FF, 32'h0, 6'd0);
      send_item(FUNC_ENCODE, 9'h001, 32'h0, 6'd0);
      send_item(FUNC_ENCODE, 9'h003, 32'h0, 6'd0);
      send_item(FUNC_ENCODE, 9'h002, 32'h0, 6'd0);
      send_item(FUNC_UNUSED, 9'h1FF, 32'hFFFF_FFFF, 6'd63); // ignored
      send_item(FUNC_ENCODE, 9'h0FF, 32'h0, 6'd0);
      send_item(FUNC_FLUSH, 9'h000, 32'h0, 6'd0);          // partial byte, then terminator
      send_item(FUNC_ENCODE, 9'h002, 32'h0, 6'd0);
      send_item(FUNC_FLUSH, 9'h1FF, 32'hFFFF_FFFF, 6'd63);
      send_item(FUNC_UNUSED, 9'h000, 32'h0, 6'd0);
      send_item(FUNC_LOAD, 9'h0FF, 32'h5555_5555, 6'd8);   // overwrite an entry
      send_item(FUNC_ENCODE, 9'h0FF, 32'h0, 6'd0);

      // Random part: mostly encodes of loaded symbols, with loads and flushes.
      for (int i = 0; i < NUM_RANDOM; i++) begin
         steady = (i % 32) < 10;
         r = $urandom_range(0, 99);
         if (r < 2) begin
            send_item(FUNC_UNUSED, SYMBOL_W'($urandom), $urandom, LEN_W'($urandom));
         end else if (r < 22 || filled_list.size() == 0) begin
            // reuse a small set of entries so reloads also happen
            idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 511)
                                               : $urandom_range(0, 15);
            send_item(FUNC_LOAD, SYMBOL_W'(idx), $urandom, pick_length());
         end else if (r < 30) begin
            send_item(FUNC_FLUSH, SYMBOL_W'($urandom), $urandom, LEN_W'($urandom));
         end else begin
            idx = filled_list[$urandom_range(0, filled_list.size() - 1)];
            send_item(FUNC_ENCODE, SYMBOL_W'(idx), $urandom, LEN_W'($urandom));
         end
      end
      send_item(FUNC_FLUSH, 9'h000, 32'h0, 6'd0);

      @(negedge clock);
      req_valid = 1'b0;

      // Drain: wait for every byte due, then watch for strays a while.
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
